// ===== hw/rtl/prd_pkg.sv =====
// Shared constants and sequencer state codes for the pulse-rate detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package prd_pkg;

	localparam int unsigned WINDOW_LEN = 32;
	localparam int unsigned FILL_W     = 6;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned PROD_W   = TICK_W + PERIOD_W;
	localparam int unsigned BPM_W    = 8;
	localparam int unsigned ADDR_W   = 3;
	localparam int unsigned DATA_W   = 32;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 12'd4095;
	localparam logic [TICK_W-1:0]   MS_PER_MIN    = 16'd60000;
	localparam logic [TICK_W-1:0]   TICK_MAX      = 16'hFFFF;
	localparam logic [BPM_W-1:0]    BPM_MAX       = 8'd200;
	localparam logic [BPM_W-1:0]    BPM_MIN       = 8'd30;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 10'd20;
	localparam logic [FILL_W-1:0]   WIN_LEN_FILL  = FILL_W'(WINDOW_LEN);

	// Register indexes
	localparam logic REG_PERIOD = 1'b0;

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WIN  = 3'd1;
	localparam logic [2:0] ST_THR  = 3'd2;
	localparam logic [2:0] ST_BEAT = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_SAT  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

endpackage

`default_nettype wire

// ===== hw/rtl/prd_divider.sv =====
// Restoring divider, one quotient bit per cycle: 60000 / divisor.
// Depends on prd_pkg for widths and the dividend constant.
`default_nettype none

module prd_divider (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [prd_pkg::TICK_W-1:0]  divisor,
	output logic                        done,
	output logic [prd_pkg::TICK_W-1:0]  quotient
);
	import prd_pkg::*;

	localparam int unsigned CNT_W = $clog2(TICK_W);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TICK_W-1:0]   rem_q;
	logic [TICK_W-1:0]   quo_q;
	logic [TICK_W-1:0]   div_q;
	logic                done_q;
	logic [TICK_W:0]     trial;
	logic                fits;

	// shift in the next dividend bit, try to subtract
	assign trial = {rem_q, quo_q[TICK_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= MS_PER_MIN;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? TICK_W'(trial - {1'b0, div_q}) : trial[TICK_W-1:0];
			quo_q <= {quo_q[TICK_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_rate_detector.sv =====
// Pulse-rate detector: each accepted sample passes the WIN, THR, BEAT and DONE states;
// the second beat of a pair adds MUL and SAT, then DIV unless the period is zero.
// in_ready is high only while the sequencer idles: a new sample waits for the last result
// to reach the output register, and the sequencer holds in DONE while that register waits.
// Reset (arst_n low, asynchronous) clears all but the payload registers, period set to 20 ms.
// Top level; depends on prd_pkg and prd_divider.
`default_nettype none

module pulse_rate_detector (
	input  wire                           clk,
	input  wire                           arst_n,
	// APB-style configuration port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [prd_pkg::ADDR_W-1:0]    paddr,
	input  wire  [prd_pkg::DATA_W-1:0]    pwdata,
	output logic [prd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// sample channel
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [prd_pkg::SAMPLE_W-1:0]  raw_sample,
	// result channel
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [prd_pkg::SAMPLE_W-1:0]  signal,
	output logic                          pulse_level,
	output logic                          beat,
	output logic                          rate_updated,
	output logic [prd_pkg::TICK_W-1:0]    ibi_ms,
	output logic [prd_pkg::BPM_W-1:0]     bpm
);
	import prd_pkg::*;

	// ---------------------------------------------------------------
	// Configuration: one register, sample period in ms, at address 0.
	// paddr[2] selects the word; anything at word 1 is ignored.
	// ---------------------------------------------------------------
	logic [PERIOD_W-1:0] period_q;
	logic                reg_sel;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && reg_sel == REG_PERIOD) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_PERIOD) begin
			prdata = DATA_W'(period_q);
		end
	end

	// ---------------------------------------------------------------
	// Detector state
	// ---------------------------------------------------------------
	logic [2:0]           state_q;
	logic [SAMPLE_W-1:0]  sig_q;
	logic [SAMPLE_W-1:0]  prev_q;
	logic [FILL_W-1:0]    fill_q;
	logic [SAMPLE_W-1:0]  wmax_q;
	logic [SAMPLE_W-1:0]  wmin_q;
	logic [SAMPLE_W-1:0]  mid_q;
	logic [SAMPLE_W-1:0]  noise_q;
	logic                 pulse_prev_q;
	logic                 parity_q;
	logic [TICK_W-1:0]    first_q;
	logic [TICK_W-1:0]    tick_q;
	logic [TICK_W-1:0]    ibi_q;
	logic [BPM_W-1:0]     bpm_q;

	// per-sample working registers
	logic                 pulse_q;
	logic                 beat_q;
	logic                 upd_q;
	logic [TICK_W-1:0]    diff_q;
	logic [PROD_W-1:0]    prod_q;

	// result register
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_sig_q;
	logic                 out_pulse_q;
	logic                 out_beat_q;
	logic                 out_upd_q;
	logic [TICK_W-1:0]    out_ibi_q;
	logic [BPM_W-1:0]     out_bpm_q;

	// divider hookup
	logic                 div_start;
	logic                 div_done;
	logic [TICK_W-1:0]    div_quo;
	logic [TICK_W-1:0]    ibi_sat;

	// window arithmetic
	logic signed [SAMPLE_W:0] rise;
	logic                     in_window;
	logic [SAMPLE_W:0]        wsum;
	logic                     pulse_now;
	logic                     beat_now;
	logic                     out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	// signed rise over the previous signal, against the noise limit
	assign rise      = signed'({1'b0, sig_q}) - signed'({1'b0, prev_q});
	assign in_window = rise < signed'({1'b0, noise_q});
	assign wsum      = {1'b0, wmax_q} + {1'b0, wmin_q};

	assign pulse_now = sig_q > mid_q;
	assign beat_now  = !pulse_prev_q && pulse_now;

	// IBI saturates at 16 bits
	assign ibi_sat   = (prod_q > PROD_W'(TICK_MAX)) ? TICK_MAX : prod_q[TICK_W-1:0];
	assign div_start = (state_q == ST_SAT) && (ibi_sat != '0);

	prd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (ibi_sat),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------
	// Sequencer
	//   WIN : window min/max update with the noise gate
	//   THR : close a full window into mid threshold and noise limit
	//   BEAT: crossing detection, beat pairing, tick bookkeeping
	//   MUL : tick distance times period
	//   SAT : saturate IBI, start the divide (or force 200 bpm at zero)
	//   DIV : wait for the quotient, clamp to 30..200
	//   DONE: hand the result to the output register when it is free
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_q       <= '0;
			fill_q       <= '0;
			wmax_q       <= '0;
			wmin_q       <= FULL_SCALE;
			mid_q        <= '0;
			noise_q      <= '0;
			pulse_prev_q <= 1'b0;
			parity_q     <= 1'b0;
			first_q      <= '0;
			tick_q       <= '0;
			ibi_q        <= '0;
			bpm_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					prev_q <= sig_q;
					if (in_window) begin
						if (sig_q > wmax_q) wmax_q <= sig_q;
						if (sig_q < wmin_q) wmin_q <= sig_q;
						fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_THR;
				end
				ST_THR: begin
					if (fill_q >= WIN_LEN_FILL) begin
						fill_q  <= '0;
						mid_q   <= wsum[SAMPLE_W:1];
						noise_q <= (wmax_q >= wmin_q) ?
							SAMPLE_W'((wmax_q - wmin_q) >> 1) : '0;
						wmax_q  <= '0;
						wmin_q  <= FULL_SCALE;
					end
					state_q <= ST_BEAT;
				end
				ST_BEAT: begin
					pulse_prev_q <= pulse_now;
					state_q      <= ST_DONE;
					if (beat_now && parity_q) begin
						// second beat of the pair: counter restarts, then ticks once
						parity_q <= 1'b0;
						tick_q   <= TICK_W'(1);
						if (tick_q > first_q) begin
							state_q <= ST_MUL;
						end
					end else begin
						if (beat_now) begin
							parity_q <= 1'b1;
							first_q  <= tick_q;
						end
						if (tick_q != TICK_MAX) tick_q <= tick_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					ibi_q <= ibi_sat;
					if (ibi_sat == '0) begin
						bpm_q   <= BPM_MAX;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (div_quo > TICK_W'(BPM_MAX)) begin
							bpm_q <= BPM_MAX;
						end else if (div_quo < TICK_W'(BPM_MIN)) begin
							bpm_q <= BPM_MIN;
						end else begin
							bpm_q <= div_quo[BPM_W-1:0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and working registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			sig_q <= FULL_SCALE - raw_sample;
			upd_q <= 1'b0;
		end
		if (state_q == ST_BEAT) begin
			pulse_q <= pulse_now;
			beat_q  <= beat_now;
			diff_q  <= tick_q - first_q;
			upd_q   <= beat_now && parity_q && (tick_q > first_q);
		end
		if (state_q == ST_MUL) begin
			prod_q <= diff_q * period_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_sig_q   <= sig_q;
			out_pulse_q <= pulse_q;
			out_beat_q  <= beat_q;
			out_upd_q   <= upd_q;
			out_ibi_q   <= ibi_q;
			out_bpm_q   <= bpm_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign signal       = out_sig_q;
	assign pulse_level  = out_pulse_q;
	assign beat         = out_beat_q;
	assign rate_updated = out_upd_q;
	assign ibi_ms       = out_ibi_q;
	assign bpm          = out_bpm_q;

endmodule

`default_nettype wire

// ===== hw/rtl/prd_checker.sv =====
// Port-level checks for the pulse-rate detector, bound to the top level.
// Depends on prd_pkg for widths and the rate limits.
`default_nettype none

module prd_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire                           in_ready,
	input  wire                           out_valid,
	input  wire                           out_ready,
	input  wire  [prd_pkg::SAMPLE_W-1:0]  signal,
	input  wire                           pulse_level,
	input  wire                           beat,
	input  wire                           rate_updated,
	input  wire  [prd_pkg::BPM_W-1:0]     bpm
);
	import prd_pkg::*;

	// one sample at a time: a transfer closes the input until the work is done
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a sample is in progress");

	// a waiting result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(signal) && $stable(bpm))
		else $error("result changed before transfer");

	// a beat is a rising crossing, so the level is high with it
	a_beat_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat |-> pulse_level)
		else $error("beat without pulse level");

	// a rate update only comes with a beat and leaves bpm within its clamp
	a_rate_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rate_updated |-> beat && bpm >= BPM_MIN && bpm <= BPM_MAX)
		else $error("rate update out of range or without beat");

endmodule

bind pulse_rate_detector prd_checker u_prd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.signal       (signal),
	.pulse_level  (pulse_level),
	.beat         (beat),
	.rate_updated (rate_updated),
	.bpm          (bpm)
);

`default_nettype wire

// ===== bench/prd_pulse_checker.sv =====
// Scoreboard for the pulse-rate detector: snoops the APB port and both streams,
// models every sample transfer and compares each result transfer in order.
// Depends on prd_pkg for widths and constants.
module prd_pulse_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [prd_pkg::ADDR_W-1:0]   paddr,
	input  logic [prd_pkg::DATA_W-1:0]   pwdata,
	input  logic [prd_pkg::DATA_W-1:0]   prdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [prd_pkg::SAMPLE_W-1:0] raw_sample,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [prd_pkg::SAMPLE_W-1:0] signal,
	input  logic                         pulse_level,
	input  logic                         beat,
	input  logic                         rate_updated,
	input  logic [prd_pkg::TICK_W-1:0]   ibi_ms,
	input  logic [prd_pkg::BPM_W-1:0]    bpm,
	input  logic                         run_done,
	output int unsigned                  fail_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import prd_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] signal;
		logic                pulse_level;
		logic                beat;
		logic                rate_updated;
		logic [TICK_W-1:0]   ibi_ms;
		logic [BPM_W-1:0]    bpm;
	} pulse_result_t;

	// model state
	logic [PERIOD_W-1:0] period_ms;
	logic [SAMPLE_W-1:0] last_signal, win_hi, win_lo, mid_level, noise_gate;
	logic [FILL_W-1:0]   win_fill;
	logic                level_q, pair_half;
	logic [TICK_W-1:0]   pair_start, tick_run, ibi_q;
	logic [BPM_W-1:0]    bpm_q;

	pulse_result_t pending_pulse_results[$];
	pulse_result_t want;
	int unsigned   result_index;
	logic          leftover_checked;

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t: result %0d, %s: got %0d, want %0d",
			$time, result_index, what, got, exp_val);
		fail_count++;
	endtask

	function automatic pulse_result_t next_pulse_result(input logic [SAMPLE_W-1:0] raw);
		pulse_result_t     r;
		logic [SAMPLE_W-1:0] sig;
		int                rise;
		logic              level;
		logic [TICK_W-1:0] second;
		int unsigned       interval, rate;
		sig  = FULL_SCALE - raw;
		rise = int'(sig) - int'(last_signal);
		last_signal = sig;
		// only samples that do not jump up by the noise limit or more feed the window
		if (rise < int'(noise_gate)) begin
			if (sig > win_hi) win_hi = sig;
			if (sig < win_lo) win_lo = sig;
			win_fill = win_fill + 1'b1;
		end
		if (win_fill >= WIN_LEN_FILL) begin
			win_fill   = '0;
			mid_level  = SAMPLE_W'((int'(win_hi) + int'(win_lo)) / 2);
			noise_gate = (win_hi >= win_lo) ? SAMPLE_W'((int'(win_hi) - int'(win_lo)) / 2) : '0;
			win_hi     = '0;
			win_lo     = FULL_SCALE;
		end
		level          = (sig > mid_level);
		r.beat         = level & ~level_q;
		level_q        = level;
		r.rate_updated = 1'b0;
		if (r.beat) begin
			pair_half = ~pair_half;
			if (pair_half) begin
				pair_start = tick_run;
			end else begin
				second   = tick_run;
				tick_run = '0;
				if (second > pair_start) begin
					interval = (32'(second) - 32'(pair_start)) * 32'(period_ms);
					if (interval > 32'(TICK_MAX)) interval = 32'(TICK_MAX);
					rate = (interval == 0) ? 32'(BPM_MAX) : 32'(MS_PER_MIN) / interval;
					if (rate > 32'(BPM_MAX)) rate = 32'(BPM_MAX);
					if (rate < 32'(BPM_MIN)) rate = 32'(BPM_MIN);
					ibi_q          = TICK_W'(interval);
					bpm_q          = BPM_W'(rate);
					r.rate_updated = 1'b1;
				end
			end
		end
		if (tick_run < TICK_MAX) tick_run = tick_run + 1'b1;
		r.signal      = sig;
		r.pulse_level = level;
		r.ibi_ms      = ibi_q;
		r.bpm         = bpm_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ms        = PERIOD_RESET;
			last_signal      = '0;
			win_fill         = '0;
			win_hi           = '0;
			win_lo           = FULL_SCALE;
			mid_level        = '0;
			noise_gate       = '0;
			level_q          = 1'b0;
			pair_half        = 1'b0;
			pair_start       = '0;
			tick_run         = '0;
			ibi_q            = '0;
			bpm_q            = '0;
			pending_pulse_results.delete();
			fail_count       = 0;
			result_index     = 0;
			leftover_checked = 1'b0;
		end else begin
			if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_PERIOD &&
					paddr[1:0] == 2'b00) begin
				if (pwrite)
					period_ms = pwdata[PERIOD_W-1:0];
				else if (prdata !== DATA_W'(period_ms))
					report_mismatch("period read-back", prdata, period_ms);
			end
			if (in_valid && in_ready)
				pending_pulse_results.push_back(next_pulse_result(raw_sample));
			if (out_valid && out_ready) begin
				if (pending_pulse_results.size() == 0) begin
					report_mismatch("result with nothing pending", signal, 0);
				end else begin
					want = pending_pulse_results.pop_front();
					if (signal !== want.signal)
						report_mismatch("signal", signal, want.signal);
					if (pulse_level !== want.pulse_level)
						report_mismatch("pulse_level", pulse_level, want.pulse_level);
					if (beat !== want.beat)
						report_mismatch("beat", beat, want.beat);
					if (rate_updated !== want.rate_updated)
						report_mismatch("rate_updated", rate_updated, want.rate_updated);
					if (ibi_ms !== want.ibi_ms)
						report_mismatch("ibi_ms", ibi_ms, want.ibi_ms);
					if (bpm !== want.bpm)
						report_mismatch("bpm", bpm, want.bpm);
				end
				result_index++;
			end
			if (run_done && !leftover_checked) begin
				if (pending_pulse_results.size() != 0)
					report_mismatch("results still pending", pending_pulse_results.size(), 0);
				leftover_checked = 1'b1;
			end
		end
	end

endmodule

// ===== bench/pulse_rate_detector_test.sv =====
// Top of the pulse-rate detector bench: clock, reset, APB set-up and sample stimulus.
// Instantiates pulse_rate_detector beside prd_pulse_checker and gives the verdict.
// Depends on prd_pkg.
module pulse_rate_detector_test;
	timeunit 1ns;
	timeprecision 1ps;
	import prd_pkg::*;

	// register map: byte address is four times the register index
	localparam logic [ADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR  = {~REG_PERIOD, 2'b00};

	// raw readings at both rails: dark gives signal 0, bright gives full scale
	localparam logic [SAMPLE_W-1:0] RAW_DARK   = 12'd4095;
	localparam logic [SAMPLE_W-1:0] RAW_BRIGHT = 12'd0;
	localparam logic [SAMPLE_W-1:0] RAW_FAINT  = 12'd3995;

	localparam int unsigned IDLE_MAX     = 11;
	localparam int unsigned FLAT_RUN     = 40;      // quiet lead-in before the first beat
	localparam int unsigned PHASE_COUNT  = 8;
	localparam int unsigned PHASE_ITEMS  = 200;
	localparam int unsigned DRAIN_CYCLES = 40;
	// worst case per sample is the divider path plus both idle gaps, over roughly 1700
	// samples; this leaves a wide margin
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata, prdata;
	logic                pready;
	logic                in_valid, in_ready;
	logic [SAMPLE_W-1:0] raw_sample;
	logic                out_valid, out_ready;
	logic [SAMPLE_W-1:0] signal;
	logic                pulse_level, beat, rate_updated;
	logic [TICK_W-1:0]   ibi_ms;
	logic [BPM_W-1:0]    bpm;
	logic                run_done;

	int unsigned fail_count;
	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count;
	// idle ceilings for each side; a draw of zero gives back-to-back transfers
	int unsigned src_idle_max  = IDLE_MAX;
	int unsigned sink_idle_max = IDLE_MAX;

	pulse_rate_detector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_sample   (raw_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.signal       (signal),
		.pulse_level  (pulse_level),
		.beat         (beat),
		.rate_updated (rate_updated),
		.ibi_ms       (ibi_ms),
		.bpm          (bpm)
	);

	prd_pulse_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_sample   (raw_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.signal       (signal),
		.pulse_level  (pulse_level),
		.beat         (beat),
		.rate_updated (rate_updated),
		.ibi_ms       (ibi_ms),
		.bpm          (bpm),
		.run_done     (run_done),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result transfers, counted so the stimulus knows when the block has drained
	always @(posedge clk) begin
		if (out_valid && out_ready) results_seen <= results_seen + 1;
	end

	// hard stop in case the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side: before each transfer, hold ready low for a random number of cycles
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, sink_idle_max);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// One APB transfer: setup cycle, access cycle, then a spare cycle so that
	// back-to-back calls never assign the same strobe twice in one step.
	task automatic apb_access(input logic is_write, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one sample after a random gap and hold it until the transfer.
	// Entered and left just after a falling edge.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		int unsigned gap;
		gap = $urandom_range(0, src_idle_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		raw_sample <= value;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every sample sent has produced its result.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_seen != items_sent) @(negedge clk);
	endtask

	// Pulse-shaped signal: a quick rise and a slower decay per wave, with jitter,
	// occasionally a new amplitude, and a sprinkling of stray readings.
	task automatic run_pulse_train(input int unsigned count, input int unsigned len_lo,
			input int unsigned len_hi);
		int unsigned done, roll;
		int wave_len, up_len, pos, amp, base, jitter, level;
		logic [SAMPLE_W-1:0] value;
		wave_len = 0;
		pos      = 0;
		amp      = 0;
		base     = 0;
		jitter   = 0;
		up_len   = 1;
		for (done = 0; done < count; done++) begin
			if (pos >= wave_len) begin
				if (wave_len == 0 || $urandom_range(0, 7) == 0) begin
					amp    = int'($urandom_range(8, 4000));
					base   = int'($urandom_range(0, 4095 - amp));
					jitter = int'($urandom_range(0, amp / 6));
				end
				wave_len = int'($urandom_range(len_lo, len_hi));
				up_len   = int'($urandom_range(1, wave_len / 2));
				pos      = 0;
			end
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				value = SAMPLE_W'($urandom);
			end else if (roll < 10) begin
				value = roll[0] ? RAW_DARK : RAW_BRIGHT;
			end else begin
				if (pos < up_len)
					level = base + amp * (pos + 1) / up_len;
				else
					level = base + amp - amp * (pos + 1 - up_len) / (wave_len - up_len);
				level = level + int'($urandom_range(0, 2 * jitter)) - jitter;
				if (level < 0) level = 0;
				if (level > 4095) level = 4095;
				value = SAMPLE_W'(4095 - level);
			end
			send_sample(value);
			pos++;
		end
	endtask

	initial begin
		int unsigned phase, period, len_lo, len_hi;
		logic [DATA_W-1:0] word;

		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		raw_sample = '0;
		run_done   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset value of the period
		apb_access(1'b0, PERIOD_ADDR, '0);

		// Flat dark signal straight after reset: no beat fires while the tick
		// counter runs. A faint beat pair then gives the first rate.
		repeat (FLAT_RUN) send_sample(RAW_DARK);
		send_sample(RAW_FAINT);
		send_sample(RAW_DARK);
		send_sample(RAW_FAINT);
		// rail-to-rail pair a couple of ticks apart: rate clamps at the top
		send_sample(RAW_DARK);
		send_sample(RAW_BRIGHT);
		send_sample(RAW_DARK);
		send_sample(RAW_BRIGHT);
		drain_results();

		// write to an unmapped index must leave the period alone; then zero period
		apb_access(1'b1, SPARE_ADDR, '1);
		apb_access(1'b0, PERIOD_ADDR, '0);
		apb_access(1'b1, PERIOD_ADDR, '0);
		apb_access(1'b0, PERIOD_ADDR, '0);
		send_sample(RAW_DARK);
		send_sample(RAW_BRIGHT);
		send_sample(RAW_DARK);
		send_sample(RAW_BRIGHT);
		drain_results();

		// long period with junk in the upper bits; slow pair clamps the rate at the bottom
		word = ~DATA_W'({PERIOD_W{1'b1}}) | DATA_W'(1000);
		apb_access(1'b1, PERIOD_ADDR, word);
		apb_access(1'b0, PERIOD_ADDR, '0);
		send_sample(RAW_DARK);
		send_sample(RAW_BRIGHT);
		send_sample(RAW_BRIGHT);
		send_sample(RAW_BRIGHT);
		send_sample(RAW_BRIGHT);
		send_sample(RAW_DARK);
		send_sample(RAW_BRIGHT);
		drain_results();

		// random phases, each with its own period
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0:       period = 1;
				1:       period = 1000;
				2:       period = 1023;
				3:       period = 0;
				6:       period = $urandom_range(0, 1023);
				default: period = $urandom_range(1, 1000);
			endcase
			if ($urandom_range(0, 2) == 0) apb_access(1'b1, SPARE_ADDR, $urandom);
			word = ($urandom & ~DATA_W'({PERIOD_W{1'b1}})) | DATA_W'(period);
			apb_access(1'b1, PERIOD_ADDR, word);
			apb_access(1'b0, PERIOD_ADDR, '0);
			// long periods get long waves as well, so the interval can saturate
			if (period >= 500) begin
				len_lo = 20;
				len_hi = 120;
			end else begin
				len_lo = 3;
				len_hi = 60;
			end
			run_pulse_train(PHASE_ITEMS, len_lo, len_hi);
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		run_done <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== pulse_rate_detector.f =====
hw/rtl/prd_pkg.sv
hw/rtl/prd_divider.sv
hw/rtl/pulse_rate_detector.sv
hw/rtl/prd_checker.sv
bench/prd_pulse_checker.sv
bench/pulse_rate_detector_test.sv
